// File: design/fau_pkg.sv
// Shared types and codes for the fraction arithmetic unit.
// Depends on nothing; the top level and the testbench refer to it by scoped names.
`default_nettype none

package fau_pkg;

    // Operation codes carried on the action field.
    typedef enum logic [1:0] {
        OP_ADD = 2'd0,
        OP_SUB = 2'd1,
        OP_MUL = 2'd2,
        OP_DIV = 2'd3
    } t_op;

    // Sequencer states, one-hot.
    typedef enum logic [12:0] {
        S_IDLE     = 13'b0000000000001,
        S_GCD_L    = 13'b0000000000010,
        S_DIV_A    = 13'b0000000000100,
        S_DIV_B    = 13'b0000000001000,
        S_PROD1    = 13'b0000000010000,
        S_PROD2    = 13'b0000000100000,
        S_PROD_DEN = 13'b0000001000000,
        S_SUM      = 13'b0000010000000,
        S_RED      = 13'b0000100000000,
        S_RED_GCD  = 13'b0001000000000,
        S_RED_DIVN = 13'b0010000000000,
        S_RED_DIVD = 13'b0100000000000,
        S_FIN      = 13'b1000000000000
    } t_state;

    // Status codes of a result word.
    localparam logic ST_OK       = 1'b0;
    localparam logic ST_DIV_ZERO = 1'b1;

endpackage

`default_nettype wire

// File: design/fraction_arith_unit.sv
// Fraction arithmetic unit: add, subtract, multiply and divide of two fractions.
// Depends on fau_pkg, fau_gcd and fau_div.
//
//  Channel  Direction  Handshake                   Payload
//  input    in         i_in_valid / o_in_stall     i_action, i_a_num, i_a_den, i_b_num, i_b_den
//  output   out        o_out_valid / i_out_stall   o_res_num, o_res_den, o_status
//
// One word at a time passes through a sequencer around one shared multiplier,
// one binary gcd unit and one bit-serial divider (M = 2*OPERAND_WIDTH bits).
// Add and multiply finish after their products; divide and subtract add a reduction
// by a gcd and two exact divisions, and subtract first brings the denominators
// together by their gcd and two more divisions.
// Reset is synchronous and active low and clears the sequencer, the wait flag and the output valid.
// A finished word waits in the output register; a new input word is taken meanwhile.
`default_nettype none

module fraction_arith_unit #(
    parameter int OPERAND_WIDTH = 16
) (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire logic                            i_in_valid,
    output logic                                 o_in_stall,
    input  wire logic [1:0]                      i_action,
    input  wire logic signed [OPERAND_WIDTH-1:0] i_a_num,
    input  wire logic [OPERAND_WIDTH-2:0]        i_a_den,
    input  wire logic signed [OPERAND_WIDTH-1:0] i_b_num,
    input  wire logic [OPERAND_WIDTH-2:0]        i_b_den,
    output logic                                 o_out_valid,
    input  wire logic                            i_out_stall,
    output logic signed [31:0]                   o_res_num,
    output logic [30:0]                          o_res_den,
    output logic                                 o_status
);

    localparam int W  = OPERAND_WIDTH;
    localparam int DW = W - 1;
    localparam int MW = 2 * W;
    localparam int EW = (MW + 1 > 32) ? MW + 1 : 32;

    // Sequencer and operand registers.
    fau_pkg::t_state r_state, n_state;
    fau_pkg::t_op    r_op, n_op;
    logic            r_wait, n_wait;
    logic            r_an_neg, n_an_neg;
    logic            r_bn_neg, n_bn_neg;
    logic [W-1:0]    r_an_mag, n_an_mag;
    logic [W-1:0]    r_bn_mag, n_bn_mag;
    logic [DW-1:0]   r_ad, n_ad;
    logic [DW-1:0]   r_bd, n_bd;
    logic [DW-1:0]   r_sa, n_sa;
    logic [DW-1:0]   r_sb, n_sb;
    logic [MW-1:0]   r_g, n_g;
    logic [MW-1:0]   r_p1, n_p1;
    logic [MW-1:0]   r_p2, n_p2;
    logic [MW-1:0]   r_den, n_den;
    logic [MW-1:0]   r_rm, n_rm;
    logic [MW-1:0]   r_rd, n_rd;
    logic            r_neg, n_neg;
    logic signed [MW:0] r_fnum, n_fnum;
    logic [MW-1:0]   r_fden, n_fden;
    logic            r_fstat, n_fstat;

    // Output register.
    logic               r_ovalid, n_ovalid;
    logic signed [31:0] r_res_num, n_res_num;
    logic [30:0]        r_res_den, n_res_den;
    logic               r_res_stat, n_res_stat;

    // Datapath nets.
    logic               w_accept;
    logic [W-1:0]       w_ma;
    logic [W-1:0]       w_mb;
    logic [MW-1:0]      w_prod;
    logic signed [MW:0] w_t1;
    logic signed [MW:0] w_t2;
    logic signed [MW:0] w_sum;
    logic [MW:0]        w_sum_abs;
    logic               w_gcd_start;
    logic [MW-1:0]      w_gcd_x;
    logic [MW-1:0]      w_gcd_y;
    logic               w_gcd_done;
    logic [MW-1:0]      w_gcd;
    logic               w_div_start;
    logic [MW-1:0]      w_dividend;
    logic               w_div_done;
    logic [MW-1:0]      w_quot;
    logic signed [EW-1:0] w_num_ext;
    logic [EW-1:0]        w_den_ext;

    assign w_accept   = i_in_valid && (r_state == fau_pkg::S_IDLE);
    assign o_in_stall = (r_state != fau_pkg::S_IDLE);

    // Shared multiplier operand selection.
    always_comb begin
        case (r_state)
            fau_pkg::S_PROD1: begin
                w_ma = r_an_mag;
                w_mb = (r_op == fau_pkg::OP_MUL) ? r_bn_mag : W'(r_sb);
            end
            fau_pkg::S_PROD2: begin
                w_ma = W'(r_sa);
                w_mb = r_bn_mag;
            end
            default: begin
                w_ma = W'(r_sa);
                w_mb = W'(r_bd);
            end
        endcase
    end

    assign w_prod = w_ma * w_mb;

    // Signed combination of the two products; multiply carries both signs on the
    // first term and subtract flips the second term.
    assign w_t1      = (r_an_neg ^ ((r_op == fau_pkg::OP_MUL) && r_bn_neg)) ?
                       -$signed({1'b0, r_p1}) : $signed({1'b0, r_p1});
    assign w_t2      = (r_bn_neg ^ (r_op == fau_pkg::OP_SUB)) ?
                       -$signed({1'b0, r_p2}) : $signed({1'b0, r_p2});
    assign w_sum     = w_t1 + w_t2;
    assign w_sum_abs = w_sum[MW] ? $unsigned(-w_sum) : $unsigned(w_sum);

    // Gcd unit operands: both denominators, or the value under reduction.
    assign w_gcd_start = ((r_state == fau_pkg::S_GCD_L) || (r_state == fau_pkg::S_RED_GCD))
                         && !r_wait;
    assign w_gcd_x     = (r_state == fau_pkg::S_GCD_L) ? MW'(r_ad) : r_rd;
    assign w_gcd_y     = (r_state == fau_pkg::S_GCD_L) ? MW'(r_bd) : r_rm;

    // Divider operands: every division here is exact, by the gcd just found.
    always_comb begin
        case (r_state)
            fau_pkg::S_DIV_A:    w_dividend = MW'(r_ad);
            fau_pkg::S_DIV_B:    w_dividend = MW'(r_bd);
            fau_pkg::S_RED_DIVN: w_dividend = r_rm;
            default:             w_dividend = r_rd;
        endcase
    end

    assign w_div_start = ((r_state == fau_pkg::S_DIV_A) || (r_state == fau_pkg::S_DIV_B) ||
                          (r_state == fau_pkg::S_RED_DIVN) || (r_state == fau_pkg::S_RED_DIVD))
                         && !r_wait;

    fau_gcd #(
        .MW (MW)
    ) u_gcd (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_gcd_start),
        .i_x     (w_gcd_x),
        .i_y     (w_gcd_y),
        .o_done  (w_gcd_done),
        .o_gcd   (w_gcd)
    );

    fau_div #(
        .MW (MW)
    ) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_div_start),
        .i_dividend (w_dividend),
        .i_divisor  (r_g),
        .o_done     (w_div_done),
        .o_quot     (w_quot)
    );

    // Final values wrap to the port widths.
    assign w_num_ext = EW'(r_fnum);
    assign w_den_ext = EW'(r_fden);

    // Sequencer.
    always_comb begin
        n_state    = r_state;
        n_op       = r_op;
        n_wait     = r_wait;
        n_an_neg   = r_an_neg;
        n_bn_neg   = r_bn_neg;
        n_an_mag   = r_an_mag;
        n_bn_mag   = r_bn_mag;
        n_ad       = r_ad;
        n_bd       = r_bd;
        n_sa       = r_sa;
        n_sb       = r_sb;
        n_g        = r_g;
        n_p1       = r_p1;
        n_p2       = r_p2;
        n_den      = r_den;
        n_rm       = r_rm;
        n_rd       = r_rd;
        n_neg      = r_neg;
        n_fnum     = r_fnum;
        n_fden     = r_fden;
        n_fstat    = r_fstat;
        n_ovalid   = r_ovalid;
        n_res_num  = r_res_num;
        n_res_den  = r_res_den;
        n_res_stat = r_res_stat;

        // The output word leaves when the receiver takes it.
        if (r_ovalid && !i_out_stall) begin
            n_ovalid = 1'b0;
        end

        unique case (r_state)
            fau_pkg::S_IDLE: begin
                if (w_accept) begin
                    n_op     = fau_pkg::t_op'(i_action);
                    n_an_neg = i_a_num[W-1];
                    n_bn_neg = i_b_num[W-1];
                    n_an_mag = i_a_num[W-1] ? $unsigned(-i_a_num) : $unsigned(i_a_num);
                    n_bn_mag = i_b_num[W-1] ? $unsigned(-i_b_num) : $unsigned(i_b_num);
                    n_ad     = i_a_den;
                    n_bd     = i_b_den;
                    n_sa     = i_a_den;
                    n_sb     = i_b_den;
                    n_p2     = '0;
                    n_wait   = 1'b0;
                    if (i_a_den == '0 || i_b_den == '0 ||
                        (i_action == fau_pkg::OP_DIV && i_b_num == '0)) begin
                        n_fnum  = '0;
                        n_fden  = MW'(1);
                        n_fstat = fau_pkg::ST_DIV_ZERO;
                        n_state = fau_pkg::S_FIN;
                    end else if (i_action == fau_pkg::OP_SUB) begin
                        n_state = fau_pkg::S_GCD_L;
                    end else begin
                        n_state = fau_pkg::S_PROD1;
                    end
                end
            end
            // Subtract: gcd of the denominators, then both scale factors.
            fau_pkg::S_GCD_L: begin
                if (!r_wait) begin
                    n_wait = 1'b1;
                end else if (w_gcd_done) begin
                    n_wait  = 1'b0;
                    n_g     = w_gcd;
                    n_state = fau_pkg::S_DIV_A;
                end
            end
            fau_pkg::S_DIV_A: begin
                if (!r_wait) begin
                    n_wait = 1'b1;
                end else if (w_div_done) begin
                    n_wait  = 1'b0;
                    n_sa    = w_quot[DW-1:0];
                    n_state = fau_pkg::S_DIV_B;
                end
            end
            fau_pkg::S_DIV_B: begin
                if (!r_wait) begin
                    n_wait = 1'b1;
                end else if (w_div_done) begin
                    n_wait  = 1'b0;
                    n_sb    = w_quot[DW-1:0];
                    n_state = fau_pkg::S_PROD1;
                end
            end
            // Products of magnitudes, one per cycle.
            fau_pkg::S_PROD1: begin
                n_p1    = w_prod;
                n_state = (r_op == fau_pkg::OP_MUL) ? fau_pkg::S_PROD_DEN : fau_pkg::S_PROD2;
            end
            fau_pkg::S_PROD2: begin
                n_p2 = w_prod;
                if (r_op == fau_pkg::OP_DIV) begin
                    n_rm    = r_p1;
                    n_rd    = w_prod;
                    n_neg   = r_an_neg ^ r_bn_neg;
                    n_state = fau_pkg::S_RED;
                end else begin
                    n_state = fau_pkg::S_PROD_DEN;
                end
            end
            fau_pkg::S_PROD_DEN: begin
                n_den   = w_prod;
                n_state = fau_pkg::S_SUM;
            end
            fau_pkg::S_SUM: begin
                if (r_op == fau_pkg::OP_SUB) begin
                    n_rm    = w_sum_abs[MW-1:0];
                    n_rd    = r_den;
                    n_neg   = w_sum[MW];
                    n_state = fau_pkg::S_RED;
                end else begin
                    n_fnum  = w_sum;
                    n_fden  = r_den;
                    n_fstat = fau_pkg::ST_OK;
                    n_state = fau_pkg::S_FIN;
                end
            end
            // Reduction of rm/rd by their gcd; a zero numerator gives 0/1.
            fau_pkg::S_RED: begin
                if (r_rm == '0) begin
                    n_fnum  = '0;
                    n_fden  = MW'(1);
                    n_fstat = fau_pkg::ST_OK;
                    n_state = fau_pkg::S_FIN;
                end else begin
                    n_state = fau_pkg::S_RED_GCD;
                end
            end
            fau_pkg::S_RED_GCD: begin
                if (!r_wait) begin
                    n_wait = 1'b1;
                end else if (w_gcd_done) begin
                    n_wait  = 1'b0;
                    n_g     = w_gcd;
                    n_state = fau_pkg::S_RED_DIVN;
                end
            end
            fau_pkg::S_RED_DIVN: begin
                if (!r_wait) begin
                    n_wait = 1'b1;
                end else if (w_div_done) begin
                    n_wait  = 1'b0;
                    n_rm    = w_quot;
                    n_state = fau_pkg::S_RED_DIVD;
                end
            end
            fau_pkg::S_RED_DIVD: begin
                if (!r_wait) begin
                    n_wait = 1'b1;
                end else if (w_div_done) begin
                    n_wait  = 1'b0;
                    n_fden  = w_quot;
                    n_fnum  = r_neg ? -$signed({1'b0, r_rm}) : $signed({1'b0, r_rm});
                    n_fstat = fau_pkg::ST_OK;
                    n_state = fau_pkg::S_FIN;
                end
            end
            // Hand the word to the output register once it is free.
            fau_pkg::S_FIN: begin
                if (!r_ovalid || !i_out_stall) begin
                    n_ovalid   = 1'b1;
                    n_res_num  = w_num_ext[31:0];
                    n_res_den  = w_den_ext[30:0];
                    n_res_stat = r_fstat;
                    n_state    = fau_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = fau_pkg::S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= fau_pkg::S_IDLE;
            r_wait   <= 1'b0;
            r_ovalid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_wait   <= n_wait;
            r_ovalid <= n_ovalid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_op       <= n_op;
        r_an_neg   <= n_an_neg;
        r_bn_neg   <= n_bn_neg;
        r_an_mag   <= n_an_mag;
        r_bn_mag   <= n_bn_mag;
        r_ad       <= n_ad;
        r_bd       <= n_bd;
        r_sa       <= n_sa;
        r_sb       <= n_sb;
        r_g        <= n_g;
        r_p1       <= n_p1;
        r_p2       <= n_p2;
        r_den      <= n_den;
        r_rm       <= n_rm;
        r_rd       <= n_rd;
        r_neg      <= n_neg;
        r_fnum     <= n_fnum;
        r_fden     <= n_fden;
        r_fstat    <= n_fstat;
        r_res_num  <= n_res_num;
        r_res_den  <= n_res_den;
        r_res_stat <= n_res_stat;
    end

    assign o_out_valid = r_ovalid;
    assign o_res_num   = r_res_num;
    assign o_res_den   = r_res_den;
    assign o_status    = r_res_stat;

    // An error word is always 0/1.
    a_err_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_status == fau_pkg::ST_DIV_ZERO) |->
        (o_res_num == 32'sd0 && o_res_den == 31'd1))
        else $error("error word is not 0/1");

    // An accepted word always starts the sequencer.
    a_leave_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall) |=> (r_state != fau_pkg::S_IDLE))
        else $error("accepted word did not start the sequencer");

    // A unit reports completion only while the sequencer waits for it.
    a_done_waited: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_gcd_done || w_div_done) |-> r_wait)
        else $error("unit finished while not awaited");

    // A new output word comes only from the finishing state.
    a_out_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> $past(r_state == fau_pkg::S_FIN))
        else $error("output valid rose outside the finishing state");

endmodule

`default_nettype wire

// File: design/fau_gcd.sv
// Iterative binary gcd unit: one shift or one compare-and-subtract per cycle.
// Stand-alone; used by the fraction arithmetic unit top level.
`default_nettype none

module fau_gcd #(
    parameter int MW = 32
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_start,
    input  wire logic [MW-1:0] i_x,
    input  wire logic [MW-1:0] i_y,
    output logic               o_done,
    output logic [MW-1:0]      o_gcd
);

    localparam int KW = $clog2(MW);

    logic          r_busy;
    logic          r_done;
    logic [KW-1:0] r_k;
    logic [MW-1:0] r_x;
    logic [MW-1:0] r_y;
    logic [MW-1:0] r_g;
    logic [MW-1:0] w_x_minus_y;
    logic [MW-1:0] w_y_minus_x;

    assign w_x_minus_y = r_x - r_y;
    assign w_y_minus_x = r_y - r_x;

    // Stein's algorithm: strip common factors of two, then subtract odd values.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_x    <= i_x;
                r_y    <= i_y;
                r_k    <= '0;
            end else if (r_busy) begin
                if (r_x == '0 || r_y == '0) begin
                    r_g    <= (r_x | r_y) << r_k;
                    r_done <= 1'b1;
                    r_busy <= 1'b0;
                end else if (!r_x[0] && !r_y[0]) begin
                    r_x <= r_x >> 1;
                    r_y <= r_y >> 1;
                    r_k <= r_k + 1'b1;
                end else if (!r_x[0]) begin
                    r_x <= r_x >> 1;
                end else if (!r_y[0]) begin
                    r_y <= r_y >> 1;
                end else if (r_x >= r_y) begin
                    r_x <= w_x_minus_y >> 1;
                end else begin
                    r_y <= w_y_minus_x >> 1;
                end
            end
        end
    end

    assign o_done = r_done;
    assign o_gcd  = r_g;

endmodule

`default_nettype wire

// File: design/fau_div.sv
// Restoring divider that produces one quotient bit per cycle.
// Stand-alone; used by the fraction arithmetic unit top level.
`default_nettype none

module fau_div #(
    parameter int MW = 32
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_start,
    input  wire logic [MW-1:0] i_dividend,
    input  wire logic [MW-1:0] i_divisor,
    output logic               o_done,
    output logic [MW-1:0]      o_quot
);

    localparam int CW = $clog2(MW + 1);

    logic          r_busy;
    logic          r_done;
    logic [CW-1:0] r_cnt;
    logic [MW-1:0] r_rem;
    logic [MW-1:0] r_quo;
    logic [MW-1:0] r_dvs;
    logic [MW:0]   w_shift;
    logic [MW:0]   w_diff;
    logic          w_fit;

    // Shift the next dividend bit into the partial remainder and trial-subtract.
    assign w_shift = {r_rem, r_quo[MW-1]};
    assign w_diff  = w_shift - {1'b0, r_dvs};
    assign w_fit   = !w_diff[MW];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CW'(MW);
                r_rem  <= '0;
                r_quo  <= i_dividend;
                r_dvs  <= i_divisor;
            end else if (r_busy) begin
                r_rem <= w_fit ? w_diff[MW-1:0] : w_shift[MW-1:0];
                r_quo <= {r_quo[MW-2:0], w_fit};
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == CW'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_done = r_done;
    assign o_quot = r_quo;

endmodule

`default_nettype wire

// File: dv/fraction_arith_unit_tb.sv
// Self-checking testbench for fraction_arith_unit: add, subtract, multiply and divide of fractions.
// Depends on fau_pkg and the fraction_arith_unit RTL; the expected fractions come from a local predictor.
`timescale 1ns / 1ps

module fraction_arith_unit_tb;

    localparam int W = 16;
    localparam int N_RANDOM = 1150;
    localparam int DRAIN_CYCLES = 400;
    localparam longint CYCLE_LIMIT = 2_000_000;

    // One input word and one result word as the block sees them.
    typedef struct {
        fau_pkg::t_op         action;
        logic signed [W-1:0]  a_num;
        logic [W-2:0]         a_den;
        logic signed [W-1:0]  b_num;
        logic [W-2:0]         b_den;
    } t_word;

    typedef struct {
        logic signed [31:0] num;
        logic [30:0]        den;
        logic               status;
    } t_frac;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic in_valid = 1'b0;
    logic in_stall;
    logic in_took = 1'b0;
    logic out_valid;
    logic out_stall = 1'b0;
    logic signed [31:0] res_num;
    logic [30:0] res_den;
    logic res_status;
    t_word cur_word = '{fau_pkg::OP_ADD, '0, '0, '0, '0};
    t_word drv_word;
    t_frac want;

    t_word word_q[$];
    t_frac want_q[$];

    int send_idle_pct = 10;
    int recv_stall_pct = 83;
    int total_words = 0;
    int n_accepted = 0;
    int n_checked = 0;
    int n_fail = 0;
    int n_flagged = 0;
    int n_by_op[4] = '{0, 0, 0, 0};
    longint cycle_count = 0;

    fraction_arith_unit #(
        .OPERAND_WIDTH(W)
    ) i_dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_stall  (in_stall),
        .i_action    (cur_word.action),
        .i_a_num     (cur_word.a_num),
        .i_a_den     (cur_word.a_den),
        .i_b_num     (cur_word.b_num),
        .i_b_den     (cur_word.b_den),
        .o_out_valid (out_valid),
        .i_out_stall (out_stall),
        .o_res_num   (res_num),
        .o_res_den   (res_den),
        .o_status    (res_status)
    );

    // Free-running 100 MHz clock.
    always begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Euclid's algorithm on unsigned magnitudes.
    function automatic longint unsigned gcd64(longint unsigned x, longint unsigned y);
        longint unsigned t;
        while (y != 0) begin
            t = x % y;
            x = y;
            y = t;
        end
        return x;
    endfunction

    // Expected fraction for one word. Add and multiply stay unreduced; subtract and
    // divide are reduced by the gcd with the sign carried in the numerator.
    function automatic t_frac frac_combine(t_word w);
        t_frac r;
        longint an, bn, num, diff;
        longint unsigned ad, bd, den, lcm, m, d, g;
        logic neg;
        logic reduce_it;
        an = w.a_num;
        bn = w.b_num;
        ad = w.a_den;
        bd = w.b_den;
        num = 0;
        den = 1;
        m = 0;
        d = 1;
        neg = 1'b0;
        reduce_it = 1'b0;
        r.status = fau_pkg::ST_OK;
        if (ad == 0 || bd == 0) begin
            r.status = fau_pkg::ST_DIV_ZERO;
        end else begin
            case (w.action)
                fau_pkg::OP_ADD: begin
                    num = an * longint'(bd) + longint'(ad) * bn;
                    den = ad * bd;
                end
                fau_pkg::OP_SUB: begin
                    lcm = ad / gcd64(ad, bd) * bd;
                    diff = longint'(lcm / ad) * an - longint'(lcm / bd) * bn;
                    neg = diff < 0;
                    m = neg ? -diff : diff;
                    d = lcm;
                    reduce_it = 1'b1;
                end
                fau_pkg::OP_MUL: begin
                    num = an * bn;
                    den = ad * bd;
                end
                default: begin
                    if (bn == 0) begin
                        r.status = fau_pkg::ST_DIV_ZERO;
                    end else begin
                        neg = (an < 0) != (bn < 0);
                        m = longint'(an < 0 ? -an : an) * bd;
                        d = ad * longint'(bn < 0 ? -bn : bn);
                        reduce_it = 1'b1;
                    end
                end
            endcase
        end
        if (reduce_it && m != 0) begin
            g = gcd64(d, m);
            m = m / g;
            d = d / g;
            num = neg ? -longint'(m) : longint'(m);
            den = d;
        end
        r.num = num[31:0];
        r.den = den[30:0];
        return r;
    endfunction

    task automatic queue_word(fau_pkg::t_op op, int an, int ad, int bn, int bd);
        t_word w;
        w.action = op;
        w.a_num = W'(an);
        w.a_den = (W-1)'(ad);
        w.b_num = W'(bn);
        w.b_den = (W-1)'(bd);
        word_q.push_back(w);
    endtask

    // Random word: small operands for frequent reduction and zero results, full-range
    // operands to toggle every bit, and a share with zero denominators.
    function automatic t_word random_word();
        t_word w;
        int kind;
        kind = $urandom_range(0, 9);
        w.action = fau_pkg::t_op'($urandom_range(0, 3));
        if (kind < 4) begin
            w.a_num = W'(int'($urandom_range(0, 40)) - 20);
            w.b_num = W'(int'($urandom_range(0, 40)) - 20);
            w.a_den = (W-1)'($urandom_range(1, 24));
            w.b_den = (W-1)'($urandom_range(1, 24));
        end else if (kind < 9) begin
            w.a_num = W'($urandom);
            w.b_num = W'($urandom);
            w.a_den = (W-1)'($urandom_range(1, 32767));
            w.b_den = (W-1)'($urandom_range(1, 32767));
        end else begin
            w.a_num = W'($urandom);
            w.b_num = W'($urandom);
            w.a_den = ($urandom_range(0, 2) == 0) ? '0 : (W-1)'($urandom);
            w.b_den = ($urandom_range(0, 2) == 0) ? '0 : (W-1)'($urandom);
        end
        if ($urandom_range(0, 15) == 0) begin
            w.b_num = '0;
        end
        if ($urandom_range(0, 15) == 0) begin
            w.a_num = '0;
        end
        return w;
    endfunction

    // Driver: presents the next pending word at the falling edge once the current
    // one has been taken, and toggles the output stall.
    always @(negedge clk) begin
        if (rst_n) begin
            if (!in_valid || in_took) begin
                if (word_q.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
                    drv_word = word_q.pop_front();
                    cur_word <= drv_word;
                    in_valid <= 1'b1;
                end else begin
                    in_valid <= 1'b0;
                end
            end
            out_stall <= ($urandom_range(0, 99) < recv_stall_pct);
        end
    end

    // Monitor: predicts each accepted word and checks each accepted result.
    always @(posedge clk) begin
        in_took <= rst_n && in_valid && !in_stall;
        if (rst_n && in_valid && !in_stall) begin
            want_q.push_back(frac_combine(cur_word));
            n_accepted++;
            n_by_op[cur_word.action]++;
        end
        if (rst_n && out_valid && !out_stall) begin
            n_checked++;
            if (want_q.size() == 0) begin
                $error("unexpected result word: %0d/%0d status %0d",
                       res_num, res_den, res_status);
                n_fail++;
            end else begin
                want = want_q.pop_front();
                if (want.status == fau_pkg::ST_DIV_ZERO) begin
                    n_flagged++;
                end
                if (res_num !== want.num) begin
                    $error("res_num: expected %0d, got %0d", want.num, res_num);
                    n_fail++;
                end
                if (res_den !== want.den) begin
                    $error("res_den: expected %0d, got %0d", want.den, res_den);
                    n_fail++;
                end
                if (res_status !== want.status) begin
                    $error("status: expected %0d, got %0d", want.status, res_status);
                    n_fail++;
                end
            end
        end
    end

    // Watchdog on the whole run.
    always @(posedge clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("Timeout after %0d cycles with %0d results outstanding",
                     cycle_count, want_q.size());
            $display("FAIL fraction_arith_unit");
            $finish;
        end
    end

    // Stimulus, idle phases and end of run.
    initial begin
        // Extreme operands under every operation.
        for (int op = 0; op < 4; op++) begin
            queue_word(fau_pkg::t_op'(op), -32768, 32767, -32768, 32767);
            queue_word(fau_pkg::t_op'(op), 32767, 1, -32768, 1);
            queue_word(fau_pkg::t_op'(op), 32767, 32767, 32767, 1);
        end
        // Subtract with a zero difference and with a negative difference.
        queue_word(fau_pkg::OP_SUB, 1, 2, 2, 4);
        queue_word(fau_pkg::OP_SUB, 1, 3, 1, 2);
        // Divide by a zero fraction, sign handling and a zero dividend.
        queue_word(fau_pkg::OP_DIV, 5, 7, 0, 3);
        queue_word(fau_pkg::OP_DIV, -3, 4, -9, 8);
        queue_word(fau_pkg::OP_DIV, 3, 4, -9, 8);
        queue_word(fau_pkg::OP_DIV, 0, 5, 3, 7);
        // Zero denominators on either side and on both.
        queue_word(fau_pkg::OP_ADD, 1, 0, 1, 1);
        queue_word(fau_pkg::OP_MUL, 1, 1, 1, 0);
        queue_word(fau_pkg::OP_SUB, 1, 0, 1, 0);
        queue_word(fau_pkg::OP_DIV, 1, 0, 0, 0);
        // Add and multiply are left unreduced.
        queue_word(fau_pkg::OP_MUL, 0, 5, -7, 3);
        queue_word(fau_pkg::OP_ADD, 1, 2, 1, 2);

        for (int i = 0; i < N_RANDOM; i++) begin
            word_q.push_back(random_word());
        end
        total_words = word_q.size();

        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Slow receiver first, then slow sender, then full rate.
        send_idle_pct = 10;
        recv_stall_pct = 83;
        wait (n_accepted >= total_words / 3);
        send_idle_pct = 83;
        recv_stall_pct = 10;
        wait (n_accepted >= 2 * total_words / 3);
        send_idle_pct = 0;
        recv_stall_pct = 0;
        wait (n_accepted == total_words && want_q.size() == 0);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Ran %0d words (%0d add, %0d sub, %0d mul, %0d div) in %0d cycles.",
                 n_accepted, n_by_op[fau_pkg::OP_ADD], n_by_op[fau_pkg::OP_SUB],
                 n_by_op[fau_pkg::OP_MUL], n_by_op[fau_pkg::OP_DIV], cycle_count);
        $display("Checked %0d results, %0d with error status, %0d mismatches.",
                 n_checked, n_flagged, n_fail);
        if (n_fail == 0 && want_q.size() == 0) begin
            $display("PASS fraction_arith_unit");
        end else begin
            $display("FAIL fraction_arith_unit");
        end
        $finish;
    end

endmodule

// File: fraction_arith_unit.f
design/fau_pkg.sv
design/fau_gcd.sv
design/fau_div.sv
design/fraction_arith_unit.sv
dv/fraction_arith_unit_tb.sv
